/* design/upwind_advection_stencil_macros.svh */
// assertion macros shared by the upwind stencil checkers
`ifndef UPWIND_ADVECTION_STENCIL_MACROS_SVH
`define UPWIND_ADVECTION_STENCIL_MACROS_SVH

// same-cycle implication, ignored while in reset
`define UAS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, ignored while in reset
`define UAS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/uas_pkg.sv */
// shared constants, types and saturation helper for the upwind stencil
package uas_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int REG_W     = 31;
  localparam int IDX_W     = 3;
  localparam int DIFF_W    = DATA_W + 1;
  localparam int PROD_W    = DATA_W + REG_W + 1;
  localparam int TERM_W    = DATA_W + DIFF_W;
  localparam int SRC_W     = DIFF_W + REG_W + 1;
  localparam int ACC_W     = TERM_W - FRAC_BITS + 2;
  localparam int NSTAGE    = 5;

  // action codes
  localparam logic [1:0] ACT_TRANSPORT = 2'd0;
  localparam logic [1:0] ACT_ADJOINT   = 2'd1;
  localparam logic [1:0] ACT_VELOCITY  = 2'd2;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_COURANT_X  = 3'd0;
  localparam logic [IDX_W-1:0] REG_COURANT_Y  = 3'd1;
  localparam logic [IDX_W-1:0] REG_SOURCE_GAIN = 3'd2;
  localparam logic [IDX_W-1:0] REG_RATE_X     = 3'd3;
  localparam logic [IDX_W-1:0] REG_RATE_Y     = 3'd4;

  // register reset values
  localparam logic [REG_W-1:0] RST_COURANT  = 31'd131072;
  localparam logic [REG_W-1:0] RST_SOURCE   = 31'd4096;
  localparam logic [REG_W-1:0] RST_RATE     = 31'd377;

  typedef struct packed {
    logic [1:0] action;
    logic       on_border;
    logic       first_layer;
  } uas_ctl_t;

  // fields that ride along the pipe unchanged
  typedef struct packed {
    uas_ctl_t          ctl;
    logic [DATA_W-1:0] center;
    logic [DATA_W-1:0] vel_x;
    logic [DATA_W-1:0] vel_y;
  } uas_pass_t;

  // stage load enables and valid bits
  typedef struct packed {
    logic [NSTAGE-1:0] load;
    logic [NSTAGE-1:0] valid;
  } uas_pipe_t;

  // clamp a wide signed value to the 32-bit signed range
  function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [ACC_W-1:0] x);
    logic signed [DATA_W-1:0] r;
    if (x[ACC_W-1:DATA_W-1] == {(ACC_W-DATA_W+1){x[ACC_W-1]}}) begin
      r = x[DATA_W-1:0];
    end else if (x[ACC_W-1]) begin
      r = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(DATA_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

/* design/uas_pipe_ctrl.sv */
// valid chain and per-stage load enables for the stencil pipeline
module uas_pipe_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              out_stall,
  output logic              in_stall,
  output uas_pkg::uas_pipe_t pipe
);
  import uas_pkg::*;

  logic [NSTAGE-1:0] valid_r;
  logic [NSTAGE-1:0] valid_nxt;
  logic [NSTAGE-1:0] load;
  logic [NSTAGE-1:0] feed;

  // a stage loads when empty or when the stage after it moves
  always_comb begin
    load[NSTAGE-1] = !valid_r[NSTAGE-1] || !out_stall;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      load[k] = !valid_r[k] || load[k+1];
    end
  end

  // valid bits shift with the data
  always_comb begin
    feed = {valid_r[NSTAGE-2:0], in_valid};
    for (int k = 0; k < NSTAGE; k++) begin
      valid_nxt[k] = load[k] ? feed[k] : valid_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign in_stall   = !load[0];
  assign pipe.load  = load;
  assign pipe.valid = valid_r;

endmodule

/* design/upwind_advection_stencil.sv */
// top level of the first-order upwind advection stencil pipeline
//
//  channel  direction  handshake            payload
//  in_      input      in_valid/in_stall    action, flags, five samples, velocity, obs, other sample
//  out_     output     out_valid/out_stall  value, vel_x, vel_y
//  cfg_     input      cfg_we               cfg_index, cfg_wdata (31 bits)
//
// five register stages: operand select, coefficient multiply, shift and clamp,
// difference multiply, sum and clamp; one word per cycle while the output is not stalled
// reset clears the valid chain and loads the default coefficients
// a stall holds the output word and backs up stage by stage; empty stages keep
// filling, so the input stalls only once every stage holds a word
module upwind_advection_stencil (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          in_action,
  input  logic                                in_on_border,
  input  logic                                in_first_layer,
  input  logic signed [uas_pkg::DATA_W-1:0]   in_center,
  input  logic signed [uas_pkg::DATA_W-1:0]   in_west,
  input  logic signed [uas_pkg::DATA_W-1:0]   in_east,
  input  logic signed [uas_pkg::DATA_W-1:0]   in_north,
  input  logic signed [uas_pkg::DATA_W-1:0]   in_south,
  input  logic signed [uas_pkg::DATA_W-1:0]   in_vel_x,
  input  logic signed [uas_pkg::DATA_W-1:0]   in_vel_y,
  input  logic signed [uas_pkg::DATA_W-1:0]   in_observed,
  input  logic signed [uas_pkg::DATA_W-1:0]   in_other_sample,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [uas_pkg::DATA_W-1:0]   out_value_out,
  output logic signed [uas_pkg::DATA_W-1:0]   out_vel_x_out,
  output logic signed [uas_pkg::DATA_W-1:0]   out_vel_y_out,
  input  logic                                cfg_we,
  input  logic [uas_pkg::IDX_W-1:0]           cfg_index,
  input  logic [uas_pkg::REG_W-1:0]           cfg_wdata
);
  import uas_pkg::*;

  localparam int CSH_W = PROD_W - FRAC_BITS;
  localparam int TSH_W = TERM_W - FRAC_BITS;
  localparam int SSH_W = SRC_W - FRAC_BITS;

  uas_pipe_t pipe;

  // configuration registers
  logic [REG_W-1:0] courant_x_r, courant_y_r, source_gain_r, rate_x_r, rate_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      courant_x_r   <= RST_COURANT;
      courant_y_r   <= RST_COURANT;
      source_gain_r <= RST_SOURCE;
      rate_x_r      <= RST_RATE;
      rate_y_r      <= RST_RATE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COURANT_X:   courant_x_r   <= cfg_wdata;
        REG_COURANT_Y:   courant_y_r   <= cfg_wdata;
        REG_SOURCE_GAIN: source_gain_r <= cfg_wdata;
        REG_RATE_X:      rate_x_r      <= cfg_wdata;
        REG_RATE_Y:      rate_y_r      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  uas_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .in_stall  (in_stall),
    .pipe      (pipe)
  );

  // stage 1: operand select and one-sided differences
  logic                     is_vel;
  logic signed [DIFF_W-1:0] c_e, w_e, e_e, n_e, s_e;
  uas_pass_t                s1_pass_nxt, s1_pass_r;
  logic signed [DATA_W-1:0] s1_ax_nxt, s1_ay_nxt, s1_ax_r, s1_ay_r;
  logic [REG_W-1:0]         s1_kx_nxt, s1_ky_nxt, s1_kx_r, s1_ky_r;
  logic signed [DIFF_W-1:0] s1_dx_nxt, s1_dy_nxt, s1_ds_nxt, s1_dx_r, s1_dy_r, s1_ds_r;

  always_comb begin
    is_vel = (in_action == ACT_VELOCITY);
    c_e = DIFF_W'(in_center);
    w_e = DIFF_W'(in_west);
    e_e = DIFF_W'(in_east);
    n_e = DIFF_W'(in_north);
    s_e = DIFF_W'(in_south);
    s1_ax_nxt = is_vel ? in_other_sample : in_vel_x;
    s1_ay_nxt = is_vel ? in_other_sample : in_vel_y;
    s1_kx_nxt = is_vel ? rate_x_r : courant_x_r;
    s1_ky_nxt = is_vel ? rate_y_r : courant_y_r;
    s1_dx_nxt = (is_vel || in_vel_x[DATA_W-1]) ? (e_e - c_e) : (c_e - w_e);
    s1_dy_nxt = (is_vel || in_vel_y[DATA_W-1]) ? (s_e - c_e) : (c_e - n_e);
    s1_ds_nxt = DIFF_W'(in_observed) - DIFF_W'(in_other_sample);
    s1_pass_nxt.ctl.action      = in_action;
    s1_pass_nxt.ctl.on_border   = in_on_border;
    s1_pass_nxt.ctl.first_layer = in_first_layer;
    s1_pass_nxt.center          = in_center;
    s1_pass_nxt.vel_x           = in_vel_x;
    s1_pass_nxt.vel_y           = in_vel_y;
  end

  always_ff @(posedge clk) begin
    if (pipe.load[0]) begin
      s1_pass_r <= s1_pass_nxt;
      s1_ax_r   <= s1_ax_nxt;
      s1_ay_r   <= s1_ay_nxt;
      s1_kx_r   <= s1_kx_nxt;
      s1_ky_r   <= s1_ky_nxt;
      s1_dx_r   <= s1_dx_nxt;
      s1_dy_r   <= s1_dy_nxt;
      s1_ds_r   <= s1_ds_nxt;
    end
  end

  // stage 2: coefficient and source products
  uas_pass_t                s2_pass_r;
  logic signed [PROD_W-1:0] s2_px_nxt, s2_py_nxt, s2_px_r, s2_py_r;
  logic signed [SRC_W-1:0]  s2_ps_nxt, s2_ps_r;
  logic signed [DIFF_W-1:0] s2_dx_r, s2_dy_r;

  assign s2_px_nxt = s1_ax_r * $signed({1'b0, s1_kx_r});
  assign s2_py_nxt = s1_ay_r * $signed({1'b0, s1_ky_r});
  assign s2_ps_nxt = s1_ds_r * $signed({1'b0, source_gain_r});

  always_ff @(posedge clk) begin
    if (pipe.load[1]) begin
      s2_pass_r <= s1_pass_r;
      s2_px_r   <= s2_px_nxt;
      s2_py_r   <= s2_py_nxt;
      s2_ps_r   <= s2_ps_nxt;
      s2_dx_r   <= s1_dx_r;
      s2_dy_r   <= s1_dy_r;
    end
  end

  // stage 3: floor shift and clamp of the coefficients, floor shift of the source product
  uas_pass_t                s3_pass_r;
  logic signed [CSH_W-1:0]  s3_cxs, s3_cys;
  logic signed [DATA_W-1:0] s3_cx_nxt, s3_cy_nxt, s3_cx_r, s3_cy_r;
  logic signed [SSH_W-1:0]  s3_src_nxt, s3_src_r;
  logic signed [DIFF_W-1:0] s3_dx_r, s3_dy_r;

  always_comb begin
    s3_cxs     = CSH_W'(s2_px_r >>> FRAC_BITS);
    s3_cys     = CSH_W'(s2_py_r >>> FRAC_BITS);
    s3_cx_nxt  = sat_data(ACC_W'(s3_cxs));
    s3_cy_nxt  = sat_data(ACC_W'(s3_cys));
    s3_src_nxt = SSH_W'(s2_ps_r >>> FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (pipe.load[2]) begin
      s3_pass_r <= s2_pass_r;
      s3_cx_r   <= s3_cx_nxt;
      s3_cy_r   <= s3_cy_nxt;
      s3_src_r  <= s3_src_nxt;
      s3_dx_r   <= s2_dx_r;
      s3_dy_r   <= s2_dy_r;
    end
  end

  // stage 4: coefficient times difference
  uas_pass_t                s4_pass_r;
  logic signed [TERM_W-1:0] s4_tx_nxt, s4_ty_nxt, s4_tx_r, s4_ty_r;
  logic signed [SSH_W-1:0]  s4_src_r;

  assign s4_tx_nxt = s3_cx_r * s3_dx_r;
  assign s4_ty_nxt = s3_cy_r * s3_dy_r;

  always_ff @(posedge clk) begin
    if (pipe.load[3]) begin
      s4_pass_r <= s3_pass_r;
      s4_tx_r   <= s4_tx_nxt;
      s4_ty_r   <= s4_ty_nxt;
      s4_src_r  <= s3_src_r;
    end
  end

  // stage 5: sums, clamp and result select
  logic signed [TSH_W-1:0]  tx, ty;
  logic signed [ACC_W-1:0]  c_w, vx_w, vy_w, acc;
  logic signed [DATA_W-1:0] flow_val, vx_upd, vy_upd;
  logic signed [DATA_W-1:0] val_nxt, vx_nxt, vy_nxt;
  logic signed [DATA_W-1:0] val_r, vx_r, vy_r;
  uas_ctl_t                 ctl;

  always_comb begin
    ctl  = s4_pass_r.ctl;
    tx   = TSH_W'(s4_tx_r >>> FRAC_BITS);
    ty   = TSH_W'(s4_ty_r >>> FRAC_BITS);
    c_w  = ACC_W'($signed(s4_pass_r.center));
    vx_w = ACC_W'($signed(s4_pass_r.vel_x));
    vy_w = ACC_W'($signed(s4_pass_r.vel_y));
    acc  = c_w - ACC_W'(tx) - ACC_W'(ty);
    if (ctl.action == ACT_ADJOINT) begin
      acc = acc + ACC_W'(s4_src_r);
    end
    flow_val = sat_data(acc);
    vx_upd   = sat_data(vx_w - ACC_W'(tx));
    vy_upd   = sat_data(vy_w - ACC_W'(ty));
    val_nxt  = '0;
    vx_nxt   = $signed(s4_pass_r.vel_x);
    vy_nxt   = $signed(s4_pass_r.vel_y);
    unique case (ctl.action)
      ACT_TRANSPORT: begin
        val_nxt = (ctl.on_border || ctl.first_layer) ? $signed(s4_pass_r.center) : flow_val;
      end
      ACT_ADJOINT: begin
        val_nxt = ctl.on_border ? '0 : flow_val;
      end
      ACT_VELOCITY: begin
        vx_nxt = vx_upd;
        vy_nxt = vy_upd;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pipe.load[4]) begin
      val_r <= val_nxt;
      vx_r  <= vx_nxt;
      vy_r  <= vy_nxt;
    end
  end

  assign out_valid     = pipe.valid[NSTAGE-1];
  assign out_value_out = val_r;
  assign out_vel_x_out = vx_r;
  assign out_vel_y_out = vy_r;

endmodule

/* design/uas_checker.sv */
// port-level checks of the upwind stencil, bound to the top level
`include "upwind_advection_stencil_macros.svh"

module uas_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic signed [uas_pkg::DATA_W-1:0] out_value_out,
  input logic signed [uas_pkg::DATA_W-1:0] out_vel_x_out,
  input logic signed [uas_pkg::DATA_W-1:0] out_vel_y_out
);
  import uas_pkg::*;

  // a waiting word stays put
  `UAS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_value_out) && $stable(out_vel_x_out) && $stable(out_vel_y_out), "output word changed under stall")

  // the input backs up only behind a stalled output word
  `UAS_ASSERT_NOW(a_stall_source, in_stall, out_valid && out_stall, "input stalled without output back-pressure")

  // pipe comes out of reset empty
  `UAS_ASSERT_NOW(a_reset_empty, $rose(rst_n), !out_valid, "output word present right after reset")

  // a free-running output never blocks the input
  `UAS_ASSERT_NOW(a_no_bubble_stall, !out_stall && $past(!out_stall), !in_stall, "input stalled while output drains")

endmodule

bind upwind_advection_stencil uas_checker u_uas_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_value_out (out_value_out),
  .out_vel_x_out (out_vel_x_out),
  .out_vel_y_out (out_vel_y_out)
);
